// File: rtl/accel_block_average_dead_reckoning_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block-average dead reckoning block.
// ----------------------------------------------------------------------------
`ifndef ACCEL_BLOCK_AVERAGE_DEAD_RECKONING_TOP_MACROS_SVH
`define ACCEL_BLOCK_AVERAGE_DEAD_RECKONING_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ABADR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ABADR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/abadr_pkg.sv
// ----------------------------------------------------------------------------
// abadr_pkg
// Types and constants shared by the block-average dead reckoning modules.
// ----------------------------------------------------------------------------
package abadr_pkg;
	localparam int unsigned AccW  = 24;
	localparam int unsigned VelW  = 32;
	localparam int unsigned PosW  = 40;
	localparam int unsigned TimeW = 48;
	localparam int unsigned SumW  = 32;
	localparam int unsigned DtW   = 26;
	localparam logic signed [SumW-1:0] GravityQ16 = 32'sd642908;
	localparam logic signed [DtW-1:0]  DtLimit    = 26'sd16777216;
	localparam logic [0:0] RegUpdatePeriod = 1'b0;

	typedef struct packed {
		logic signed [AccW-1:0] accel_x;
		logic signed [AccW-1:0] accel_y;
		logic signed [AccW-1:0] accel_z;
		logic [TimeW-1:0]       sample_time;
	} in_beat_t;

	typedef struct packed {
		logic signed [AccW-1:0] avg_accel_x;
		logic signed [AccW-1:0] avg_accel_y;
		logic signed [AccW-1:0] avg_accel_z;
		logic signed [VelW-1:0] vel_x;
		logic signed [VelW-1:0] vel_y;
		logic signed [VelW-1:0] vel_z;
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [PosW-1:0] pos_z;
		logic [TimeW-1:0]       result_time;
	} out_beat_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} lane_ctl_t;
endpackage

// File: rtl/abadr_lane.sv
// ----------------------------------------------------------------------------
// abadr_lane
// One axis: sums samples, divides the block sum by the count serially, then
// integrates velocity and position over a few sequencer steps.
// ----------------------------------------------------------------------------
module abadr_lane import abadr_pkg::*; #(
	parameter bit AddGravity = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   add_en,
	input  logic signed [AccW-1:0] sample,
	input  logic                   start,
	input  logic [7:0]             count,
	input  logic signed [DtW-1:0]  dt,
	output logic                   busy,
	output logic                   done,
	output logic signed [AccW-1:0] avg,
	output logic signed [VelW-1:0] vel,
	output logic signed [PosW-1:0] pos
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_MEAN, S_DV, S_VEL, S_DP, S_DPM, S_DPC, S_POS
	} st_t;

	st_t st_q;
	logic signed [SumW-1:0] sum_q;
	logic [SumW-1:0] mag_q, quo_q;
	logic [7:0] rem_q;
	logic [5:0] it_q;
	logic neg_q;
	logic signed [SumW:0] a_full;
	logic signed [AccW-1:0] a_q;
	logic signed [55:0] prod_q;
	logic signed [40:0] dv_q;
	logic signed [VelW-1:0] vel_q;
	logic signed [PosW-1:0] pos_q;
	logic signed [PosW+1:0] vsum;
	logic signed [9:0] rem_try;
	logic signed [SumW:0] q_signed;
	logic signed [40:0] dv_c;
	logic signed [34:0] vv2;
	logic signed [60:0] dpm_q;
	logic signed [43:0] dp_c;
	logic signed [43:0] dp_q;
	logic signed [45:0] psum;

	assign rem_try  = $signed({1'b0, rem_q, mag_q[SumW-1]}) - $signed({2'b0, count});
	assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign a_full   = AddGravity ? q_signed + (SumW+1)'(GravityQ16) : q_signed;
	assign dv_c     = prod_q[55] ? -41'($signed(-prod_q) >>> 16) : 41'(prod_q >>> 16);
	assign vsum     = (PosW+2)'(vel_q) + (PosW+2)'(dv_q);
	assign vv2      = 35'(dv_q) + (35'(vel_q) <<< 1);
	assign dp_c     = dpm_q[60] ? -44'((-dpm_q) >>> 17) : 44'(dpm_q >>> 17);
	assign psum     = 46'(pos_q) + 46'(dp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			sum_q <= '0;
			vel_q <= '0;
			pos_q <= '0;
			it_q  <= '0;
		end else begin
			if (add_en)
				sum_q <= sum_q + SumW'(sample);
			case (st_q)
				S_IDLE: begin
					if (start) begin
						neg_q <= sum_q[SumW-1];
						mag_q <= sum_q[SumW-1] ? -sum_q : sum_q;
						sum_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						it_q  <= '0;
						st_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (!rem_try[9]) begin
						rem_q <= rem_try[7:0];
						quo_q <= {quo_q[SumW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[6:0], mag_q[SumW-1]};
						quo_q <= {quo_q[SumW-2:0], 1'b0};
					end
					mag_q <= {mag_q[SumW-2:0], 1'b0};
					it_q  <= it_q + 6'd1;
					if (it_q == 6'(SumW-1))
						st_q <= S_MEAN;
				end
				S_MEAN: begin
					if (a_full > (SumW+1)'(33'sd8388607))
						a_q <= 24'sh7FFFFF;
					else if (a_full < -(SumW+1)'(33'sd8388608))
						a_q <= 24'sh800000;
					else
						a_q <= a_full[AccW-1:0];
					st_q <= S_DV;
				end
				S_DV: begin
					prod_q <= 56'(a_q) * 56'(dt);
					st_q   <= S_VEL;
				end
				S_VEL: begin
					dv_q <= dv_c;
					st_q <= S_DP;
				end
				S_DP: begin
					if (vsum > (PosW+2)'(42'sh7FFFFFFF))
						vel_q <= 32'sh7FFFFFFF;
					else if (vsum < -(PosW+2)'(42'sh80000000))
						vel_q <= 32'sh80000000;
					else
						vel_q <= vsum[VelW-1:0];
					st_q <= S_DPM;
				end
				S_DPM: begin
					dpm_q <= 61'(vv2) * 61'(dt);
					st_q  <= S_DPC;
				end
				S_DPC: begin
					dp_q <= dp_c;
					st_q <= S_POS;
				end
				S_POS: begin
					if (psum > 46'sh7FFFFFFFFF)
						pos_q <= 40'sh7FFFFFFFFF;
					else if (psum < -46'sh8000000000)
						pos_q <= 40'sh8000000000;
					else
						pos_q <= psum[PosW-1:0];
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign vel   = vel_q;
	assign pos   = pos_q;
	assign avg   = a_q;
	assign busy  = (st_q != S_IDLE);
	assign done  = (st_q == S_POS);
endmodule

// File: rtl/accel_block_average_dead_reckoning_top.sv
// ----------------------------------------------------------------------------
// accel_block_average_dead_reckoning_top
// Block-average dead reckoning: per-axis lanes, a block controller and an
// output register that merges the lanes' results into one beat.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// apb     | config    | psel / penable / pwrite, pready always high
// A sample that does not close a block leaves the input open for the next sample.
// A closing sample's result beat passes through a start register, the 32-step serial
// divide and seven integration steps in each lane, and the merge of the lanes into the
// output register.
// The input stalls while lanes work or a result beat waits.
// Reset clears sums, velocity, position and time to zero; the period resets to 10.
module accel_block_average_dead_reckoning_top import abadr_pkg::*; #(
	parameter int unsigned AXES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] period_q, count_q, n_s1;
	logic [TimeW-1:0] last_time_q, time_s1;
	logic have_prev_q, busy_q, out_valid_q;
	logic signed [DtW-1:0] dt_q;
	logic signed [TimeW:0] tdiff;
	logic [7:0] period_eff, n_next;
	logic accept, closing;
	logic start_s1;
	logic signed [AccW-1:0] samp [3];
	logic signed [AccW-1:0] avg_l [3];
	logic signed [VelW-1:0] vel_l [3];
	logic signed [PosW-1:0] pos_l [3];
	lane_ctl_t ctl [3];
	out_beat_t out_q;

	assign pready     = 1'b1;
	assign prdata     = {24'b0, period_q};
	assign accept     = in_valid && !in_stall;
	assign period_eff = (period_q == 8'd0) ? 8'd1 : period_q;
	assign n_next     = count_q + 8'd1;
	assign closing    = accept && (n_next >= period_eff);
	assign in_stall   = busy_q || out_valid_q;
	assign tdiff      = $signed({1'b0, in_data.sample_time}) - $signed({1'b0, last_time_q});
	assign samp[0]    = in_data.accel_x;
	assign samp[1]    = in_data.accel_y;
	assign samp[2]    = in_data.accel_z;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		if (g < AXES) begin : g_on
			abadr_lane #(.AddGravity(g == 2)) u_lane (
				.clk(clk), .arst_n(arst_n), .add_en(accept), .sample(samp[g]),
				.start(ctl[g].start), .count(n_s1), .dt(dt_q),
				.busy(ctl[g].busy), .done(ctl[g].done),
				.avg(avg_l[g]), .vel(vel_l[g]), .pos(pos_l[g])
			);
		end else begin : g_off
			assign ctl[g].busy = 1'b0;
			assign ctl[g].done = 1'b0;
			assign avg_l[g] = '0;
			assign vel_l[g] = '0;
			assign pos_l[g] = '0;
		end
		assign ctl[g].start = start_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= 8'd10;
			count_q     <= '0;
			last_time_q <= '0;
			have_prev_q <= 1'b0;
			busy_q      <= 1'b0;
			start_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_s1 <= 1'b0;
			if (psel && penable && pwrite && paddr == 2'(RegUpdatePeriod))
				period_q <= pwdata[7:0];
			if (accept)
				count_q <= closing ? 8'd0 : n_next;
			if (closing) begin
				busy_q      <= 1'b1;
				start_s1    <= 1'b1;
				n_s1        <= n_next;
				time_s1     <= in_data.sample_time;
				last_time_q <= in_data.sample_time;
				have_prev_q <= 1'b1;
				if (!have_prev_q)
					dt_q <= '0;
				else if (tdiff > (TimeW+1)'(DtLimit))
					dt_q <= DtLimit;
				else if (tdiff < -(TimeW+1)'(DtLimit))
					dt_q <= -DtLimit;
				else
					dt_q <= tdiff[DtW-1:0];
			end
			if (busy_q && !start_s1 && !ctl[0].busy && !ctl[1].busy && !ctl[2].busy) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				out_q <= '{avg_accel_x: avg_l[0], avg_accel_y: avg_l[1],
					avg_accel_z: avg_l[2], vel_x: vel_l[0], vel_y: vel_l[1],
					vel_z: vel_l[2], pos_x: pos_l[0], pos_y: pos_l[1],
					pos_z: pos_l[2], result_time: time_s1};
			end else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// File: rtl/abadr_checker.sv
// ----------------------------------------------------------------------------
// abadr_checker
// Port-level checks of the block-average dead reckoning block.
// ----------------------------------------------------------------------------
`include "accel_block_average_dead_reckoning_top_macros.svh"
module abadr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic pready
);
	`ABADR_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready, "pready low")
	`ABADR_ASSERT_IMP(a_stall_out, clk, arst_n, out_valid, in_stall, "input open with beat held")
	`ABADR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "beat dropped")
	`ABADR_ASSERT_IMP(a_take_idle, clk, arst_n, in_valid && !in_stall, !out_valid, "beat taken while result held")
endmodule

bind accel_block_average_dead_reckoning_top abadr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pready(pready)
);

// File: tb/accel_block_average_dead_reckoning_checker.sv
// ----------------------------------------------------------------------------
// accel_block_average_dead_reckoning_checker
// Watches the sample, result and register ports of the dead reckoning block,
// predicts every result beat from the accepted samples and compares each
// received beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module accel_block_average_dead_reckoning_checker import abadr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_beat_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          blocks_checked,
	output int          blocks_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint DtMax = 64'sd16777216;

	logic [7:0]  period;
	logic [7:0]  count;
	int          sums [3];
	longint      vel_state [3];
	longint      pos_state [3];
	logic [47:0] last_time;
	bit          have_prev;
	out_beat_t   expected_blocks [$];

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic longint shr_trunc(input longint x, input int s);
		return (x < 0) ? -((-x) >>> s) : (x >>> s);
	endfunction

	function automatic bit predict_block(input in_beat_t b, output out_beat_t r);
		longint acc [3];
		longint avg [3];
		longint per, n, dt, a, dv;
		int i;
		acc[0] = b.accel_x;
		acc[1] = b.accel_y;
		acc[2] = b.accel_z;
		per = (period == 0) ? 1 : period;
		n = longint'(count) + 1;
		r = '0;
		for (i = 0; i < 3; i++) begin
			sums[i] = sums[i] + int'(acc[i]);
		end
		if (n < per) begin
			count = n[7:0];
			return 1'b0;
		end
		dt = 0;
		if (have_prev) begin
			dt = clamp(longint'(b.sample_time) - longint'(last_time), -DtMax, DtMax);
		end
		for (i = 0; i < 3; i++) begin
			a = longint'(sums[i]) / n;
			if (i == 2) begin
				a = a + longint'(GravityQ16);
			end
			a = clamp(a, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
			dv = shr_trunc(a * dt, 16);
			vel_state[i] = clamp(vel_state[i] + dv, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
			pos_state[i] = clamp(pos_state[i] + shr_trunc(dv * dt + 2 * vel_state[i] * dt, 17),
				-(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
			avg[i] = a;
			sums[i] = 0;
		end
		r.avg_accel_x = avg[0][23:0];
		r.avg_accel_y = avg[1][23:0];
		r.avg_accel_z = avg[2][23:0];
		r.vel_x = vel_state[0][31:0];
		r.vel_y = vel_state[1][31:0];
		r.vel_z = vel_state[2][31:0];
		r.pos_x = pos_state[0][39:0];
		r.pos_y = pos_state[1][39:0];
		r.pos_z = pos_state[2][39:0];
		r.result_time = b.sample_time;
		count = '0;
		last_time = b.sample_time;
		have_prev = 1'b1;
		return 1'b1;
	endfunction

	function automatic void split_fields(input out_beat_t r, output logic [63:0] f [10]);
		f[0] = 64'(r.avg_accel_x);
		f[1] = 64'(r.avg_accel_y);
		f[2] = 64'(r.avg_accel_z);
		f[3] = 64'(r.vel_x);
		f[4] = 64'(r.vel_y);
		f[5] = 64'(r.vel_z);
		f[6] = 64'(r.pos_x);
		f[7] = 64'(r.pos_y);
		f[8] = 64'(r.pos_z);
		f[9] = 64'(r.result_time);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		out_beat_t   predicted;
		out_beat_t   oldest;
		logic [63:0] exp_f [10];
		logic [63:0] act_f [10];
		string       names [10];
		names = '{"avg_accel_x", "avg_accel_y", "avg_accel_z", "vel_x", "vel_y", "vel_z",
			"pos_x", "pos_y", "pos_z", "result_time"};
		if (!arst_n) begin
			period = 8'd10;
			count = '0;
			sums = '{0, 0, 0};
			vel_state = '{0, 0, 0};
			pos_state = '{0, 0, 0};
			last_time = '0;
			have_prev = 1'b0;
			expected_blocks.delete();
			fail_count <= 0;
			blocks_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: result beat with none expected, actual %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					oldest = expected_blocks.pop_front();
					split_fields(oldest, exp_f);
					split_fields(out_data, act_f);
					for (int i = 0; i < 10; i++) begin
						if (exp_f[i] !== act_f[i]) begin
							$display("%0t: %s mismatch, expected %h actual %h",
								$time, names[i], exp_f[i], act_f[i]);
						end
					end
					if (oldest !== out_data) begin
						fail_count <= fail_count + 1;
					end
					blocks_checked <= blocks_checked + 1;
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_block(in_data, predicted)) begin
					expected_blocks.push_back(predicted);
				end
			end
			if (psel && penable && pwrite && pready && paddr == 2'(RegUpdatePeriod)) begin
				period = pwdata[7:0];
			end
		end
	end

	assign blocks_pending = expected_blocks.size();
endmodule

// File: tb/accel_block_average_dead_reckoning_top_tb.sv
// ----------------------------------------------------------------------------
// accel_block_average_dead_reckoning_top_tb
// Drives timestamped acceleration samples and block period settings into the
// dead reckoning block under varying idle and stall patterns; a separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module accel_block_average_dead_reckoning_top_tb import abadr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 20000;
	localparam int SettleCycles  = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_beat_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_beat_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          blocks_checked;
	int          blocks_pending;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;
	int          samples_sent = 0;
	int          settings_used = 0;
	logic [47:0] now_time = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	accel_block_average_dead_reckoning_top i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	accel_block_average_dead_reckoning_checker i_checker (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .blocks_checked, .blocks_pending
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Watchdog expired with %0d results outstanding", blocks_pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_sample(input logic [23:0] ax, input logic [23:0] ay,
		input logic [23:0] az, input logic [47:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{accel_x: ax, accel_y: ay, accel_z: az, sample_time: t};
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (blocks_pending != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_period(input logic [7:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 2'(RegUpdatePeriod);
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [23:0] rand_accel();
		case ($urandom_range(4))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($signed($urandom_range(4000)) - 2000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] next_time();
		case ($urandom_range(19))
			0: now_time = 48'({$urandom, $urandom});
			1: now_time = now_time - 48'($urandom_range(1 << 20));
			2: now_time = now_time + 48'd33554432;
			default: now_time = now_time + 48'($urandom_range(1 << 18));
		endcase
		return now_time;
	endfunction

	initial begin
		int per;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_period(8'd1);
		send_sample(24'h000000, 24'h000000, 24'h000000, 48'h0);
		send_sample(24'h7fffff, 24'h7fffff, 24'h7fffff, 48'h10000);
		send_sample(24'h800000, 24'h800000, 24'h800000, 48'h20000);
		send_sample(24'h7fffff, 24'h800000, 24'h000001, 48'h8000);
		send_sample(24'h7fffff, 24'h7fffff, 24'h7fffff, 48'hffff_ffff_ffff);
		send_sample(24'h7fffff, 24'h800000, 24'h7fffff, 48'h0);
		send_sample(24'h7fffff, 24'h800000, 24'h7fffff, 48'h0200_0000);
		send_sample(24'h7fffff, 24'h800000, 24'h7fffff, 48'h0400_0000);
		send_sample(24'h800000, 24'h7fffff, 24'h800000, 48'h0600_0000);
		send_sample(24'hffffff, 24'h000001, 24'hf63000, 48'h0600_0001);
		write_period(8'd0);
		send_sample(24'h123456, 24'hedcba9, 24'h000100, 48'h0600_1000);
		send_sample(24'h7fffff, 24'h000000, 24'h800000, 48'h0600_2000);
		write_period(8'd4);
		send_sample(24'h000007, 24'hfffff9, 24'h000003, 48'h0600_3000);
		send_sample(24'h000002, 24'hfffffe, 24'h000000, 48'h0600_4000);
		send_sample(24'h000001, 24'hffffff, 24'h000000, 48'h0600_5000);
		write_period(8'd2);
		send_sample(24'h000001, 24'h000000, 24'hffffff, 48'h0600_6000);
		now_time = 48'h0600_6000;

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  per = 3; end
				1: begin idle_pct = 57; stall_pct = 0;  per = 1; end
				2: begin idle_pct = 0;  stall_pct = 57; per = 255; end
				3: begin idle_pct = 17; stall_pct = 17; per = $urandom_range(2, 12); end
				default: begin idle_pct = 0; stall_pct = 0; per = 5; end
			endcase
			write_period(8'(per));
			for (int k = 0; k < ((per == 255) ? 255 : 36); k++) begin
				if (phase == 3 && k == 18) begin
					drain();
				end
				send_sample(rand_accel(), rand_accel(), rand_accel(), next_time());
			end
		end
		drain();
		idle_pct = 0;
		stall_pct = 0;
		write_period(8'd10);
		repeat (10) send_sample(rand_accel(), rand_accel(), rand_accel(), next_time());
		drain();

		$display("Sent %0d samples over %0d period settings; %0d result beats checked.",
			samples_sent, settings_used, blocks_checked);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// File: accel_block_average_dead_reckoning_top.f
+incdir+rtl
rtl/abadr_pkg.sv
rtl/abadr_lane.sv
rtl/accel_block_average_dead_reckoning_top.sv
rtl/abadr_checker.sv
tb/accel_block_average_dead_reckoning_checker.sv
tb/accel_block_average_dead_reckoning_top_tb.sv
